>>> rtl/tsc_pkg.sv
// ----------------------------------------------------------------------------
// Triangle set containment package
// Shared types and codes for the triangle set and its cell chain.
// ----------------------------------------------------------------------------
package tsc_pkg;

   localparam int CORNER_W = 32;
   localparam int OPCODE_W = 2;

   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
   localparam int OP_CHECK_BIT = 1;

   typedef enum logic [2:0] {
      ST_STORED     = 3'd0,
      ST_PRESENT    = 3'd1,
      ST_DEGENERATE = 3'd2,
      ST_FULL       = 3'd3,
      ST_FOUND      = 3'd4,
      ST_MISSING    = 3'd5,
      ST_CLEARED    = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_WALK,
      FSM_DONE
   } fsm_type;

   typedef struct packed {
      logic [CORNER_W-1:0] lowest;
      logic [CORNER_W-1:0] middle;
      logic [CORNER_W-1:0] trailing;
   } triangle_type;

   typedef struct packed {
      logic         active;
      logic         check;
      triangle_type shape;
      logic         hit;
      logic         stored;
   } token_type;

endpackage

>>> rtl/tsc_canon.sv
// ----------------------------------------------------------------------------
// Triangle canonical form
// Flags a degenerate triangle and rotates the corners, keeping the winding,
// so that the smallest signed index comes first.
// ----------------------------------------------------------------------------
module tsc_canon (
   input  logic [tsc_pkg::CORNER_W-1:0] corner_a_i,
   input  logic [tsc_pkg::CORNER_W-1:0] corner_b_i,
   input  logic [tsc_pkg::CORNER_W-1:0] corner_c_i,
   output logic                         degenerate_o,
   output tsc_pkg::triangle_type        tri_o
);
   import tsc_pkg::*;

   logic a_le_b;
   logic a_le_c;
   logic b_le_c;

   assign a_le_b = $signed(corner_a_i) <= $signed(corner_b_i);
   assign a_le_c = $signed(corner_a_i) <= $signed(corner_c_i);
   assign b_le_c = $signed(corner_b_i) <= $signed(corner_c_i);

   assign degenerate_o = (corner_a_i == corner_b_i) || (corner_a_i == corner_c_i) ||
                         (corner_b_i == corner_c_i);

   always_comb begin
      if (a_le_b && a_le_c) begin
         tri_o.lowest   = corner_a_i;
         tri_o.middle   = corner_b_i;
         tri_o.trailing = corner_c_i;
      end else if (b_le_c) begin
         tri_o.lowest   = corner_b_i;
         tri_o.middle   = corner_c_i;
         tri_o.trailing = corner_a_i;
      end else begin
         tri_o.lowest   = corner_c_i;
         tri_o.middle   = corner_a_i;
         tri_o.trailing = corner_b_i;
      end
   end

endmodule

>>> rtl/tsc_cell.sv
// ----------------------------------------------------------------------------
// Triangle set entry cell
// Holds one stored triangle, compares the passing token against it, claims
// the token for storage when the cell is the first free one, and hands the
// token on to the next cell in the following cycle.
// ----------------------------------------------------------------------------
module tsc_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               clear_i,
   input  tsc_pkg::token_type tok_i,
   output tsc_pkg::token_type tok_o
);
   import tsc_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   triangle_type entry_ff;
   triangle_type entry_in;
   token_type    tok_ff;
   token_type    tok_in;
   logic         match;
   logic         store;

   assign match = valid_ff && (entry_ff == tok_i.shape);
   assign store = tok_i.active && !tok_i.check && !tok_i.hit && !tok_i.stored && !valid_ff;

   always_comb begin
      tok_in        = tok_i;
      tok_in.hit    = tok_i.hit || (tok_i.active && match);
      tok_in.stored = tok_i.stored || store;
      valid_in      = clear_i ? 1'b0 : (valid_ff || store);
      entry_in      = store ? tok_i.shape : entry_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign tok_o = tok_ff;

endmodule

>>> rtl/triangle_set_containment.sv
// ----------------------------------------------------------------------------
// Triangle set containment
// Keeps a bounded set of canonical triangles in a chain of entry cells,
// inserts mesh A triangles, checks mesh B triangles and reports one result
// beat per request beat.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | contents
//  req_    | in        | req_tvalid / req_tready  | three corners, opcode, last mark
//  rsp_    | out       | rsp_tvalid / rsp_tready  | status, flags, entry count, last mark
//
// An insert or check beat walks the whole cell chain, one cell per cycle;
// the next request is accepted only after its result has been loaded.
// A clear beat or a degenerate triangle goes to the result without the walk.
// Reset empties the set, sets the all-matched flag and clears overflow.
// A result waiting on rsp_tready holds the next request only once that
// request's result is ready too.
// ----------------------------------------------------------------------------
module triangle_set_containment #(
   parameter int SET_CAPACITY = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,  // corner_first, corner_second, corner_third
   input  logic [1:0]  req_tuser,  // opcode
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // status, all_matched, entry_count, overflowed, zeros
   output logic        rsp_tlast
);
   import tsc_pkg::*;

   localparam int CNT_W = $clog2(SET_CAPACITY + 1);

   fsm_type      state_ff;
   fsm_type      state_in;
   token_type    head_ff;
   token_type    head_in;
   status_type   status_ff;
   status_type   status_in;
   logic         last_ff;
   logic         last_in;
   logic         match_ff;
   logic         match_in;
   logic         ovf_ff;
   logic         ovf_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic [15:0]  rsp_data_ff;
   logic [15:0]  rsp_data_in;
   logic         rsp_last_ff;
   logic         rsp_last_in;

   logic         accept;
   logic         clear_cells;
   logic         rsp_load;
   logic         degenerate;
   triangle_type canon_tri;
   token_type    chain [0:SET_CAPACITY];
   token_type    tail;

   tsc_canon u_canon (
      .corner_a_i   (req_tdata[31:0]),
      .corner_b_i   (req_tdata[63:32]),
      .corner_c_i   (req_tdata[95:64]),
      .degenerate_o (degenerate),
      .tri_o        (canon_tri)
   );

   assign chain[0] = head_ff;
   assign tail     = chain[SET_CAPACITY];

   for (genvar i = 0; i < SET_CAPACITY; i++) begin : g_cell
      tsc_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .clear_i (clear_cells),
         .tok_i   (chain[i]),
         .tok_o   (chain[i+1])
      );
   end

   assign accept      = req_tvalid && req_tready;
   assign clear_cells = accept && (req_tuser == OP_CLEAR);

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      head_in.active = 1'b0;
      status_in      = status_ff;
      last_in        = last_ff;
      match_in       = match_ff;
      ovf_in         = ovf_ff;
      count_in       = count_ff;
      req_tready     = 1'b0;
      rsp_load       = 1'b0;
      case (state_ff)
         FSM_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               last_in = req_tlast;
               if (req_tuser == OP_CLEAR) begin
                  match_in  = 1'b1;
                  ovf_in    = 1'b0;
                  count_in  = '0;
                  status_in = ST_CLEARED;
                  state_in  = FSM_DONE;
               end else if (degenerate) begin
                  status_in = ST_DEGENERATE;
                  state_in  = FSM_DONE;
               end else begin
                  head_in.active = 1'b1;
                  head_in.check  = req_tuser[OP_CHECK_BIT];
                  head_in.shape  = canon_tri;
                  head_in.hit    = 1'b0;
                  head_in.stored = 1'b0;
                  state_in       = FSM_WALK;
               end
            end
         end
         FSM_WALK: begin
            if (tail.active) begin
               state_in = FSM_DONE;
               if (tail.check) begin
                  if (tail.hit) begin
                     status_in = ST_FOUND;
                  end else begin
                     status_in = ST_MISSING;
                     match_in  = 1'b0;
                  end
               end else if (tail.hit) begin
                  status_in = ST_PRESENT;
               end else if (tail.stored) begin
                  status_in = ST_STORED;
                  count_in  = count_ff + CNT_W'(1);
               end else begin
                  status_in = ST_FULL;
                  ovf_in    = 1'b1;
               end
            end
         end
         FSM_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_load) begin
         rsp_data_in = {2'b00, ovf_ff, 9'(count_ff), match_ff, status_ff};
         rsp_last_in = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         head_ff      <= '0;
         match_ff     <= 1'b1;
         ovf_ff       <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         match_ff     <= match_in;
         ovf_ff       <= ovf_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> bench/triangle_set_containment_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Triangle set containment testbench
// Streams clear, insert and check beats into the triangle set and compares
// every result beat with a cycle-free model of the canonical triangle set.
// Directed beats cover the corner extremes, rotations, degenerate triangles
// and the odd opcode. A fill phase drives the set past capacity. Random
// lists of inserts and checks follow. Both sides stall at random.
// ----------------------------------------------------------------------------
module triangle_set_containment_tb;
   import tsc_pkg::*;

   localparam int SET_CAPACITY = 256;
   localparam int BEAT_TARGET = 800;
   localparam int QUIET_LIMIT = 3000;
   localparam int LONG_HOLD = 800;
   localparam int SHOWN_ERRORS = 20;

   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CHECK = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_CHECK_ALT = 2'd3;

   typedef struct {
      logic [OPCODE_W-1:0] opcode;
      logic [CORNER_W-1:0] first;
      logic [CORNER_W-1:0] second;
      logic [CORNER_W-1:0] third;
      logic                last;
      bit                  drain_first;
   } tri_beat_type;

   typedef struct {
      status_type status;
      logic       all_matched;
      logic [8:0] entry_count;
      logic       overflowed;
      logic       final_mark;
   } verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;   // corner_first, corner_second, corner_third
   logic [1:0]  req_tuser = '0;   // opcode
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // status, all_matched, entry_count, overflowed, zeros
   logic        rsp_tlast;

   triangle_type kept_tris [SET_CAPACITY];
   bit           kept_valid [SET_CAPACITY];
   int unsigned  kept_count = 0;
   bit           all_found = 1'b1;
   bit           refused = 1'b0;

   tri_beat_type pending [$];
   verdict_type  verdict_q [$];
   tri_beat_type on_bus;
   int        beats_taken = 0;
   int        verdicts_seen = 0;
   int        mismatches = 0;
   int        drains = 0;
   int        quiet = 0;
   int        status_hits [8];

   triangle_set_containment #(.SET_CAPACITY(SET_CAPACITY)) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic triangle_type canonical(logic [CORNER_W-1:0] p, logic [CORNER_W-1:0] q,
                                              logic [CORNER_W-1:0] r);
      if ($signed(p) <= $signed(q) && $signed(p) <= $signed(r))
         return {p, q, r};
      else if ($signed(q) <= $signed(r))
         return {q, r, p};
      else
         return {r, p, q};
   endfunction

   function automatic verdict_type judge_triangle(tri_beat_type b);
      verdict_type  v;
      triangle_type key;
      bit           hit;
      hit = 1'b0;
      if (b.opcode == OP_CLEAR) begin
         foreach (kept_valid[i]) kept_valid[i] = 1'b0;
         kept_count = 0;
         all_found = 1'b1;
         refused = 1'b0;
         v.status = ST_CLEARED;
      end else if (b.first == b.second || b.first == b.third || b.second == b.third) begin
         v.status = ST_DEGENERATE;
      end else begin
         key = canonical(b.first, b.second, b.third);
         for (int i = 0; i < SET_CAPACITY; i++)
            if (kept_valid[i] && kept_tris[i] == key) hit = 1'b1;
         if (b.opcode[OP_CHECK_BIT]) begin
            v.status = hit ? ST_FOUND : ST_MISSING;
            if (!hit) all_found = 1'b0;
         end else if (hit) begin
            v.status = ST_PRESENT;
         end else if (kept_count >= SET_CAPACITY) begin
            refused = 1'b1;
            v.status = ST_FULL;
         end else begin
            kept_tris[kept_count] = key;
            kept_valid[kept_count] = 1'b1;
            kept_count++;
            v.status = ST_STORED;
         end
      end
      v.all_matched = all_found;
      v.entry_count = kept_count[8:0];
      v.overflowed = refused;
      v.final_mark = b.last;
      return v;
   endfunction

   task automatic report_mismatch(string field, longint want, longint got);
      mismatches++;
      if (mismatches <= SHOWN_ERRORS)
         $display("Mismatch at result %0d: %s expected %0d, got %0d",
                  verdicts_seen, field, want, got);
   endtask

   // Sender: offers the head of the pending queue and predicts each accepted beat.
   always @(posedge clock) begin : feed
      bit calm;
      bit blocked;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            verdict_q.push_back(judge_triangle(on_bus));
            beats_taken++;
         end
         if (!req_tvalid || req_tready) begin
            calm = beats_taken >= 150 && beats_taken < 270;
            blocked = pending.size() == 0 ||
                      (pending[0].drain_first && verdict_q.size() != 0) ||
                      (!calm && $urandom_range(0, 99) < 10);
            if (!blocked) begin
               on_bus = pending.pop_front();
               if (on_bus.drain_first) drains++;
               req_tdata <= {on_bus.third, on_bus.second, on_bus.first};
               req_tuser <= on_bus.opcode;
               req_tlast <= on_bus.last;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each result beat and applies back-pressure.
   always @(posedge clock) begin : drain
      verdict_type want;
      int          hold_left;
      bit          hold_done;
      bit          calm;
      status_type  got_status;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
         hold_done = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_status = status_type'(rsp_tdata[2:0]);
            if (verdict_q.size() == 0) begin
               report_mismatch("unexpected result beat, status", -1, rsp_tdata[2:0]);
            end else begin
               want = verdict_q.pop_front();
               if (got_status !== want.status)
                  report_mismatch("status", want.status, rsp_tdata[2:0]);
               if (rsp_tdata[3] !== want.all_matched)
                  report_mismatch("all_matched", want.all_matched, rsp_tdata[3]);
               if (rsp_tdata[12:4] !== want.entry_count)
                  report_mismatch("entry_count", want.entry_count, rsp_tdata[12:4]);
               if (rsp_tdata[13] !== want.overflowed)
                  report_mismatch("overflowed", want.overflowed, rsp_tdata[13]);
               if (rsp_tlast !== want.final_mark)
                  report_mismatch("verdict_final", want.final_mark, rsp_tlast);
               status_hits[want.status]++;
            end
            verdicts_seen++;
         end
         if (!hold_done && verdicts_seen == 60) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         calm = verdicts_seen >= 300 && verdicts_seen < 420;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || $urandom_range(0, 99) >= 10;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("Timeout: no beat moved for %0d cycles", QUIET_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

   task automatic queue_tri(logic [OPCODE_W-1:0] op, triangle_type t, bit last, bit drain_first);
      tri_beat_type b;
      b.opcode = op;
      b.first = t.lowest;
      b.second = t.middle;
      b.third = t.trailing;
      b.last = last;
      b.drain_first = drain_first;
      pending.push_back(b);
   endtask

   // Rotations 0 to 2 keep the winding; 3 reverses it.
   function automatic triangle_type spin(triangle_type t, int k);
      case (k)
         0: return t;
         1: return {t.middle, t.trailing, t.lowest};
         2: return {t.trailing, t.lowest, t.middle};
         default: return {t.lowest, t.trailing, t.middle};
      endcase
   endfunction

   function automatic logic [CORNER_W-1:0] random_corner();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 32'($urandom_range(0, 8)) - 32'd4;
         4: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'h0000_0000;
               default: return 32'hffff_ffff;
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   function automatic triangle_type random_triangle();
      return {random_corner(), random_corner(), random_corner()};
   endfunction

   initial begin
      triangle_type        t;
      triangle_type        pool [$];
      logic [CORNER_W-1:0] base;
      int                  n_ins;
      int                  n_chk;
      int                  pick;

      // Directed part.
      queue_tri(OP_CLEAR, {32'd9, 32'd9, 32'd9}, 1'b0, 1'b0);
      queue_tri(OP_INSERT, {32'd1, 32'd2, 32'd3}, 1'b0, 1'b0);
      queue_tri(OP_INSERT, {32'd2, 32'd3, 32'd1}, 1'b0, 1'b0);
      queue_tri(OP_INSERT, {32'd3, 32'd2, 32'd1}, 1'b0, 1'b0);
      queue_tri(OP_INSERT, {32'd5, 32'd5, 32'd7}, 1'b0, 1'b0);
      queue_tri(OP_INSERT, {32'd7, 32'd5, 32'd5}, 1'b0, 1'b0);
      queue_tri(OP_CHECK, {32'd5, 32'd7, 32'd5}, 1'b0, 1'b0);
      queue_tri(OP_CHECK, {32'd3, 32'd1, 32'd2}, 1'b0, 1'b0);
      queue_tri(OP_CHECK_ALT, {32'd2, 32'd3, 32'd1}, 1'b0, 1'b0);
      queue_tri(OP_CHECK_ALT, {32'd4, 32'd4, 32'd4}, 1'b0, 1'b0);
      queue_tri(OP_CHECK, {32'd9, 32'd8, 32'd7}, 1'b1, 1'b0);
      queue_tri(OP_INSERT, {32'h8000_0000, 32'h7fff_ffff, 32'h0}, 1'b0, 1'b0);
      queue_tri(OP_INSERT, {32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff}, 1'b0, 1'b0);
      queue_tri(OP_INSERT, {32'hffff_ffff, 32'hffff_fffe, 32'hffff_fffd}, 1'b0, 1'b0);
      queue_tri(OP_CHECK, {32'h0, 32'h8000_0000, 32'h7fff_ffff}, 1'b0, 1'b0);
      queue_tri(OP_CHECK, {32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000}, 1'b0, 1'b0);
      queue_tri(OP_CHECK, {32'hffff_fffd, 32'hffff_ffff, 32'hffff_fffe}, 1'b0, 1'b0);
      queue_tri(OP_CHECK, {32'hffff_ffff, 32'hffff_fffd, 32'hffff_fffe}, 1'b1, 1'b0);
      queue_tri(OP_CLEAR, {32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff}, 1'b1, 1'b1);
      queue_tri(OP_CHECK_ALT, {32'd1, 32'd2, 32'd3}, 1'b1, 1'b0);

      // Fill the set past capacity, then probe it while full.
      base = 32'($urandom_range(0, 2000000)) - 32'd1000000;
      queue_tri(OP_CLEAR, random_triangle(), 1'b0, 1'b1);
      for (int k = 0; k < SET_CAPACITY + 4; k++) begin
         t = {base + 32'(k), base + 32'(k) + 32'd5000, base + 32'(k) + 32'd9000};
         queue_tri(OP_INSERT, spin(t, $urandom_range(0, 2)), 1'b0, 1'b0);
      end
      t = {base + 32'd3, base + 32'd5003, base + 32'd9003};
      queue_tri(OP_INSERT, spin(t, 1), 1'b0, 1'b0);
      queue_tri(OP_INSERT, {base, base, base + 32'd1}, 1'b0, 1'b0);
      t = {base + 32'd100, base + 32'd5100, base + 32'd9100};
      queue_tri(OP_CHECK, spin(t, 2), 1'b0, 1'b0);
      queue_tri(OP_CHECK, spin(t, 3), 1'b0, 1'b0);
      t = {base + 32'd258, base + 32'd5258, base + 32'd9258};
      queue_tri(OP_CHECK, t, 1'b1, 1'b0);
      queue_tri(OP_CLEAR, random_triangle(), 1'b1, 1'b0);

      // Random lists: inserts, then checks mostly of inserted triangles.
      while (pending.size() < BEAT_TARGET) begin
         pool.delete();
         n_ins = $urandom_range(1, 10);
         n_chk = $urandom_range(1, 10);
         if ($urandom_range(0, 9) != 0)
            queue_tri(OP_CLEAR, random_triangle(), 1'b0, $urandom_range(0, 7) == 0);
         repeat (n_ins) begin
            if (pool.size() != 0 && $urandom_range(0, 5) == 0) begin
               t = spin(pool[$urandom_range(0, pool.size() - 1)], $urandom_range(0, 2));
            end else begin
               t = random_triangle();
               pool.push_back(t);
            end
            queue_tri(OP_INSERT, t, 1'b0, 1'b0);
            if ($urandom_range(0, 9) == 0)
               queue_tri(2'($urandom_range(0, 3)), random_triangle(), $urandom_range(0, 1), 1'b0);
         end
         for (int k = 0; k < n_chk; k++) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
               t = spin(pool[$urandom_range(0, pool.size() - 1)], $urandom_range(0, 2));
            else if (pick < 8)
               t = spin(pool[$urandom_range(0, pool.size() - 1)], 3);
            else
               t = random_triangle();
            queue_tri(($urandom_range(0, 3) == 0) ? OP_CHECK_ALT : OP_CHECK, t,
                      k == n_chk - 1, 1'b0);
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending.size() != 0 || req_tvalid) @(posedge clock);
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (2 * (SET_CAPACITY + 3)) @(posedge clock);

      $display("Covered %0d beats: %0d stored, %0d duplicates, %0d degenerate, %0d refused full,",
               verdicts_seen, status_hits[ST_STORED], status_hits[ST_PRESENT],
               status_hits[ST_DEGENERATE], status_hits[ST_FULL]);
      $display("  %0d found, %0d missing, %0d clears; %0d sender drains, %0d mismatches.",
               status_hits[ST_FOUND], status_hits[ST_MISSING], status_hits[ST_CLEARED],
               drains, mismatches);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

>>> filelist.f
rtl/tsc_pkg.sv
rtl/tsc_canon.sv
rtl/tsc_cell.sv
rtl/triangle_set_containment.sv
bench/triangle_set_containment_tb.sv
